>>> design/iad_pkg.sv
// Shared constants for the integer to decimal ASCII converter.
// Used by the double-dabble step unit and the top-level sequencer.
`timescale 1ns / 1ps
`default_nettype none

package iad_pkg;

    localparam int unsigned BIN_W      = 64;
    localparam int unsigned DIGITS     = 20;
    localparam int unsigned BCD_W      = DIGITS * 4;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned BITCNT_W   = 7;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [BIN_W-1:0] bin_t;

endpackage

`default_nettype wire

>>> design/iad_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion.
// Depends on iad_pkg for the BCD and binary register types.
`timescale 1ns / 1ps
`default_nettype none

module iad_dabble_step (
    input  wire iad_pkg::bcd_t bcd_in,
    input  wire iad_pkg::bin_t bin_in,
    output iad_pkg::bcd_t      bcd_out,
    output iad_pkg::bin_t      bin_out
);

    iad_pkg::bcd_t adj;

    always_comb
    begin
        for (int i = 0; i < iad_pkg::DIGITS; i++)
        begin
            if (bcd_in[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_in[i*4 +: 4];
            end
        end
    end

    assign bcd_out = {adj[iad_pkg::BCD_W-2:0], bin_in[iad_pkg::BIN_W-1]};
    assign bin_out = {bin_in[iad_pkg::BIN_W-2:0], 1'b0};

endmodule

`default_nettype wire

>>> design/integer_to_decimal_ascii_top.sv
// Top level of the integer to decimal ASCII converter: sequencer and output register.
// Depends on iad_pkg and iad_dabble_step.
`timescale 1ns / 1ps
`default_nettype none

// An accepted request is converted to BCD by one shift-and-add-3 unit that handles one
// operand bit per cycle, over 8, 16, 32 or 64 operand bits according to the width code.
// Leading zero digits are then dropped one per cycle (at most 19), and the text is sent
// one character per cycle while the output is not stalled, with a sign character first
// for negative values. No new request is taken until the last character has been
// handed to the output register. The output register lets a character wait while
// work continues.
module integer_to_decimal_ascii_top (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [63:0] value,
    input  wire [1:0]  width_code,
    input  wire        is_signed,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] character,
    output logic       last,
    output logic [4:0] text_length
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    iad_pkg::bcd_t                   bcd_reg;
    iad_pkg::bin_t                   bin_reg;
    logic [iad_pkg::BITCNT_W-1:0]    cnt_reg;
    logic [iad_pkg::LEN_W-1:0]       digits_reg;
    logic [iad_pkg::LEN_W-1:0]       len_reg;
    logic                            neg_reg;
    logic                            out_valid_reg;
    logic [7:0]                      char_reg;
    logic                            last_reg;
    logic [iad_pkg::LEN_W-1:0]       length_reg;

    iad_pkg::bcd_t                   bcd_next;
    iad_pkg::bin_t                   bin_next;
    iad_pkg::bin_t                   mask;
    iad_pkg::bin_t                   sign_bit;
    iad_pkg::bin_t                   trunc;
    iad_pkg::bin_t                   magnitude;
    iad_pkg::bin_t                   aligned;
    logic [iad_pkg::BITCNT_W-1:0]    bit_count;
    logic                            negative;
    logic                            slot_free;
    logic                            out_load;
    logic [3:0]                      top_digit;

    iad_dabble_step u_step (
        .bcd_in  (bcd_reg),
        .bin_in  (bin_reg),
        .bcd_out (bcd_next),
        .bin_out (bin_next)
    );

    always_comb
    begin
        unique case (width_code)
            iad_pkg::WIDTH_8:
            begin
                mask      = 64'h0000_0000_0000_00FF;
                sign_bit  = 64'h0000_0000_0000_0080;
                bit_count = 7'd8;
            end
            iad_pkg::WIDTH_16:
            begin
                mask      = 64'h0000_0000_0000_FFFF;
                sign_bit  = 64'h0000_0000_0000_8000;
                bit_count = 7'd16;
            end
            iad_pkg::WIDTH_32:
            begin
                mask      = 64'h0000_0000_FFFF_FFFF;
                sign_bit  = 64'h0000_0000_8000_0000;
                bit_count = 7'd32;
            end
            default:
            begin
                mask      = 64'hFFFF_FFFF_FFFF_FFFF;
                sign_bit  = 64'h8000_0000_0000_0000;
                bit_count = 7'd64;
            end
        endcase
        trunc    = value & mask;
        negative = is_signed && ((trunc & sign_bit) != 64'd0);
        if (negative)
        begin
            magnitude = (64'd0 - trunc) & mask;
        end
        else
        begin
            magnitude = trunc;
        end
        unique case (width_code)
            iad_pkg::WIDTH_8:  aligned = magnitude << 56;
            iad_pkg::WIDTH_16: aligned = magnitude << 48;
            iad_pkg::WIDTH_32: aligned = magnitude << 32;
            default:           aligned = magnitude;
        endcase
    end

    assign top_digit = bcd_reg[iad_pkg::BCD_W-1 -: 4];
    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = slot_free && ((state_reg == ST_SIGN) || (state_reg == ST_EMIT));
    assign in_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            digits_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        bin_reg   <= aligned;
                        bcd_reg   <= '0;
                        cnt_reg   <= bit_count;
                        neg_reg   <= negative;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bcd_reg <= bcd_next;
                    bin_reg <= bin_next;
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        digits_reg <= iad_pkg::LEN_W'(iad_pkg::DIGITS);
                        state_reg  <= ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    if (top_digit == 4'd0 && digits_reg > 5'd1)
                    begin
                        bcd_reg    <= {bcd_reg[iad_pkg::BCD_W-5:0], 4'd0};
                        digits_reg <= digits_reg - 5'd1;
                    end
                    else
                    begin
                        len_reg   <= digits_reg + {4'd0, neg_reg};
                        state_reg <= neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
                ST_SIGN:
                begin
                    if (slot_free)
                    begin
                        char_reg      <= iad_pkg::ASCII_MINUS;
                        last_reg      <= 1'b0;
                        length_reg    <= '0;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        char_reg      <= iad_pkg::ASCII_ZERO + {4'd0, top_digit};
                        last_reg      <= (digits_reg == 5'd1);
                        length_reg    <= (digits_reg == 5'd1) ? len_reg : 5'd0;
                        bcd_reg       <= {bcd_reg[iad_pkg::BCD_W-5:0], 4'd0};
                        digits_reg    <= digits_reg - 5'd1;
                        if (digits_reg == 5'd1)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign character   = char_reg;
    assign last        = last_reg;
    assign text_length = length_reg;

endmodule

`default_nettype wire

>>> dv/integer_to_decimal_ascii_top_tb.sv
// Self-checking bench for integer_to_decimal_ascii_top: directed corner rows, then random requests.
// Every emitted character is checked against the row's given text or a decimal text predictor. Depends on iad_pkg.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_top_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_REQS  = 126;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 120;

    typedef struct packed {
        iad_pkg::bin_t val;
        logic [1:0]    wc;
        logic          sgn;
    } conv_req_t;

    typedef struct packed {
        logic [7:0]                ch;
        logic                      fin;
        logic [iad_pkg::LEN_W-1:0] len;
    } char_exp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value;
    logic [1:0]  width_code;
    logic        is_signed;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  character;
    logic        last;
    logic [4:0]  text_length;

    char_exp_t   pending_chars[$];
    conv_req_t   dir_reqs[$];
    string       dir_texts[$];
    logic [7:0]  text_buf [0:iad_pkg::DIGITS-1];
    int          text_len;
    int          mismatches;
    int          cycle_count;
    bit          calm;
    bit          hold_req;
    int          hold_left;

    integer_to_decimal_ascii_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .width_code  (width_code),
        .is_signed   (is_signed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .character   (character),
        .last        (last),
        .text_length (text_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic iad_pkg::bin_t width_mask(input logic [1:0] wc);
        case (wc)
            iad_pkg::WIDTH_8:  return 64'hFF;
            iad_pkg::WIDTH_16: return 64'hFFFF;
            iad_pkg::WIDTH_32: return 64'hFFFF_FFFF;
            default:           return 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic iad_pkg::bin_t sign_mask(input logic [1:0] wc);
        case (wc)
            iad_pkg::WIDTH_8:  return 64'h80;
            iad_pkg::WIDTH_16: return 64'h8000;
            iad_pkg::WIDTH_32: return 64'h8000_0000;
            default:           return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    task automatic predict_text(input conv_req_t r);
        iad_pkg::bin_t mask;
        iad_pkg::bin_t mag;
        iad_pkg::bin_t rem;
        logic          neg;
        logic [3:0]    dig [0:iad_pkg::DIGITS-1];
        int            nd;
        int            pos;
        mask = width_mask(r.wc);
        mag  = r.val & mask;
        neg  = r.sgn && ((mag & sign_mask(r.wc)) != 64'd0);
        if (neg)
            mag = (~mag + 64'd1) & mask;
        nd = 0;
        do
        begin
            rem     = mag % 64'd10;
            dig[nd] = rem[3:0];
            mag     = mag / 64'd10;
            nd++;
        end
        while (mag != 64'd0 && nd < iad_pkg::DIGITS);
        pos = 0;
        if (neg)
        begin
            text_buf[0] = iad_pkg::ASCII_MINUS;
            pos = 1;
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            text_buf[pos] = iad_pkg::ASCII_ZERO + {4'd0, dig[k]};
            pos++;
        end
        text_len = pos;
    endtask

    task automatic load_text(input string txt);
        text_len = txt.len();
        for (int i = 0; i < text_len; i++)
            text_buf[i] = txt[i];
    endtask

    task automatic queue_text();
        char_exp_t e;
        for (int i = 0; i < text_len; i++)
        begin
            e.ch  = text_buf[i];
            e.fin = (i == text_len - 1);
            e.len = e.fin ? text_len[iad_pkg::LEN_W-1:0] : '0;
            pending_chars.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input iad_pkg::bin_t v, input logic [1:0] wc, input logic sgn,
                           input string txt);
        conv_req_t r;
        r.val = v;
        r.wc  = wc;
        r.sgn = sgn;
        dir_reqs.push_back(r);
        dir_texts.push_back(txt);
    endtask

    task automatic send_request(input conv_req_t r, input string txt);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        value      <= r.val;
        width_code <= r.wc;
        is_signed  <= r.sgn;
        do
            @(posedge clk);
        while (!in_ready);
        if (txt.len() > 0)
            load_text(txt);
        else
            predict_text(r);
        queue_text();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
    endtask

    function automatic conv_req_t random_req();
        conv_req_t     r;
        iad_pkg::bin_t pick;
        iad_pkg::bin_t p10;
        int            kind;
        r.wc  = 2'($urandom_range(0, 3));
        r.sgn = 1'($urandom_range(0, 1));
        kind  = $urandom_range(0, 9);
        case (kind)
            4: r.val = 64'($urandom_range(0, 20));
            5:
            begin
                case ($urandom_range(0, 5))
                    0: pick = sign_mask(r.wc) - 64'd1;
                    1: pick = sign_mask(r.wc);
                    2: pick = sign_mask(r.wc) + 64'd1;
                    3: pick = width_mask(r.wc);
                    4: pick = width_mask(r.wc) - 64'd1;
                    default: pick = 64'd0;
                endcase
                if ($urandom_range(0, 1) == 1)
                    pick = pick | ({$urandom, $urandom} & ~width_mask(r.wc));
                r.val = pick;
            end
            6:
            begin
                p10 = 64'd1;
                for (int i = $urandom_range(0, 19); i > 0; i--)
                    p10 = p10 * 64'd10;
                r.val = p10 + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: r.val = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge clk)
    begin : check_output
        char_exp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                report_mismatch("character without request", character, 0);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (character !== want.ch)
                    report_mismatch("character", character, want.ch);
                if (last !== want.fin)
                    report_mismatch("last", last, want.fin);
                if (text_length !== want.len)
                    report_mismatch("text_length", text_length, want.len);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : main_flow
        conv_req_t r;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value       = '0;
        width_code  = iad_pkg::WIDTH_8;
        is_signed   = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;

        add_row(64'h0, iad_pkg::WIDTH_8, 1'b0, "0");
        add_row(64'hFF, iad_pkg::WIDTH_8, 1'b0, "255");
        add_row(64'h80, iad_pkg::WIDTH_8, 1'b1, "-128");
        add_row(64'h7F, iad_pkg::WIDTH_8, 1'b1, "127");
        add_row(64'hFF, iad_pkg::WIDTH_8, 1'b1, "-1");
        add_row(64'h8000, iad_pkg::WIDTH_16, 1'b1, "-32768");
        add_row(64'hFFFF, iad_pkg::WIDTH_16, 1'b0, "65535");
        add_row(64'h7FFF, iad_pkg::WIDTH_16, 1'b1, "32767");
        add_row(64'h8000_0000, iad_pkg::WIDTH_32, 1'b1, "-2147483648");
        add_row(64'hFFFF_FFFF, iad_pkg::WIDTH_32, 1'b0, "4294967295");
        add_row(64'h8000_0000_0000_0000, iad_pkg::WIDTH_64, 1'b1, "-9223372036854775808");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, iad_pkg::WIDTH_64, 1'b0, "18446744073709551615");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, iad_pkg::WIDTH_64, 1'b1, "-1");
        add_row(64'h7FFF_FFFF_FFFF_FFFF, iad_pkg::WIDTH_64, 1'b1, "9223372036854775807");
        add_row(64'h0, iad_pkg::WIDTH_64, 1'b1, "0");
        add_row(64'd10000000000000000000, iad_pkg::WIDTH_64, 1'b0, "10000000000000000000");
        add_row(64'hFFFF_FFFF_FFFF_FF00, iad_pkg::WIDTH_8, 1'b0, "0");
        add_row(64'hAAAA_5555_1234_0009, iad_pkg::WIDTH_16, 1'b1, "");
        add_row(64'h0000_0000_DEAD_BEEF, iad_pkg::WIDTH_32, 1'b1, "");
        add_row(64'hFFFF_FFFF_FFFF_FF85, iad_pkg::WIDTH_32, 1'b1, "");
        add_row(64'd9999999999999999999, iad_pkg::WIDTH_64, 1'b0, "");
        add_row(64'd1000000000000000000, iad_pkg::WIDTH_64, 1'b1, "");
        add_row(64'h1234_5678_9ABC_DEF0, iad_pkg::WIDTH_64, 1'b0, "");
        add_row(64'h5555_AAAA_0F0F_F0F0, iad_pkg::WIDTH_64, 1'b1, "");

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_reqs.size(); i++)
            send_request(dir_reqs[i], dir_texts[i]);

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == 20)
                wait_drained();
            calm = (i >= 40 && i < 80);
            if (i == 100)
                hold_req = 1'b1;
            r = random_req();
            send_request(r, "");
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
design/iad_pkg.sv
design/iad_dabble_step.sv
design/integer_to_decimal_ascii_top.sv
dv/integer_to_decimal_ascii_top_tb.sv
